@@ sv/lpi_pkg.sv @@
package lpi_pkg;

  // Arithmetic constants of the evaluation.
  localparam int STEP_MS    = 100;
  localparam int DIVIDEND_W = 32;
  localparam int FRAC_W     = 7;
  localparam int COUNT_W    = 6;
  localparam int BRIGHT_W   = 16;
  localparam int ENTRY_W    = 9;

  // 5243 / 2^19 lies just above 1/100; the excess stays below one step for any
  // remainder under 43690, so the scaled product gives the exact quotient.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;

  localparam logic [ENTRY_W-1:0]         LETTER_BASE = 9'd97;
  localparam logic signed [BRIGHT_W-1:0] UNIT_FULL   = 16'sd1200;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_LENGTH = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;

  // Datapath operations.
  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_WR_LETTER  = 4'd1;
  localparam logic [3:0] OP_WR_LEN     = 4'd2;
  localparam logic [3:0] OP_LOAD_MOD   = 4'd3;
  localparam logic [3:0] OP_DIV_STEP   = 4'd4;
  localparam logic [3:0] OP_LOAD_SPLIT = 4'd5;
  localparam logic [3:0] OP_RD_CUR     = 4'd6;
  localparam logic [3:0] OP_MAC_CUR    = 4'd7;
  localparam logic [3:0] OP_MAC_PREV   = 4'd8;
  localparam logic [3:0] OP_TAKE_FRAC  = 4'd9;

  // Result sources.
  localparam logic [1:0] EMIT_NONE   = 2'd0;
  localparam logic [1:0] EMIT_ACC    = 2'd1;
  localparam logic [1:0] EMIT_FULL   = 2'd2;
  localparam logic [1:0] EMIT_REJECT = 2'd3;

  // Jump conditions.
  localparam logic [1:0] COND_NONE     = 2'd0;
  localparam logic [1:0] COND_LOOP     = 2'd1;
  localparam logic [1:0] COND_NO_LEN   = 2'd2;
  localparam logic [1:0] COND_TOO_LONG = 2'd3;

  // Program addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_WRITE      = 4'd0;
  localparam logic [PC_W-1:0] PC_LENGTH     = 4'd1;
  localparam logic [PC_W-1:0] PC_REJECT     = 4'd2;
  localparam logic [PC_W-1:0] PC_EVAL       = 4'd3;
  localparam logic [PC_W-1:0] PC_MOD        = 4'd4;
  localparam logic [PC_W-1:0] PC_MOD_LOOP   = 4'd5;
  localparam logic [PC_W-1:0] PC_SPLIT      = 4'd6;
  localparam logic [PC_W-1:0] PC_FRAC       = 4'd7;
  localparam logic [PC_W-1:0] PC_RD_CUR     = 4'd8;
  localparam logic [PC_W-1:0] PC_MAC_CUR    = 4'd9;
  localparam logic [PC_W-1:0] PC_MAC_PREV   = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT       = 4'd11;
  localparam logic [PC_W-1:0] PC_FULL       = 4'd12;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      emit;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctrl_t;

  typedef struct packed {
    logic too_long;
    logic no_len;
    logic more;
  } dp_status_t;

  localparam ctrl_t CTRL_IDLE = '{op: OP_NOP, emit: EMIT_NONE, cond: COND_NONE,
                                  target: PC_WRITE, done: 1'b0};

  // The control store. A jump that is taken overrides the done bit.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, emit: EMIT_NONE, cond: COND_NONE, target: PC_WRITE, done: 1'b1};
    unique case (pc)
      PC_WRITE:      c = '{OP_WR_LETTER,  EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b1};
      PC_LENGTH:     c = '{OP_WR_LEN,     EMIT_NONE,   COND_TOO_LONG, PC_REJECT,     1'b1};
      PC_REJECT:     c = '{OP_NOP,        EMIT_REJECT, COND_NONE,     PC_WRITE,      1'b1};
      PC_EVAL:       c = '{OP_NOP,        EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b0};
      PC_MOD:        c = '{OP_LOAD_MOD,   EMIT_NONE,   COND_NO_LEN,   PC_FULL,       1'b0};
      PC_MOD_LOOP:   c = '{OP_DIV_STEP,   EMIT_NONE,   COND_LOOP,     PC_MOD_LOOP,   1'b0};
      PC_SPLIT:      c = '{OP_LOAD_SPLIT, EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b0};
      PC_FRAC:       c = '{OP_TAKE_FRAC,  EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b0};
      PC_RD_CUR:     c = '{OP_RD_CUR,     EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b0};
      PC_MAC_CUR:    c = '{OP_MAC_CUR,    EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b0};
      PC_MAC_PREV:   c = '{OP_MAC_PREV,   EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b0};
      PC_EMIT:       c = '{OP_NOP,        EMIT_ACC,    COND_NONE,     PC_WRITE,      1'b1};
      PC_FULL:       c = '{OP_NOP,        EMIT_FULL,   COND_NONE,     PC_WRITE,      1'b1};
      default:       c = '{OP_NOP,        EMIT_NONE,   COND_NONE,     PC_WRITE,      1'b1};
    endcase
    return c;
  endfunction

endpackage

@@ sv/lpi_sequencer.sv @@
module lpi_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  lpi_pkg::dp_status_t status,
  input  logic                out_blocked,
  output lpi_pkg::ctrl_t      ctrl,
  output logic                busy
);
  import lpi_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;
  ctrl_t           word;
  logic            hold;
  logic            taken;

  assign word = ucode(pc);

  // A step that delivers a result waits while the output register is still full.
  assign hold = (word.emit != EMIT_NONE) && out_blocked;
  assign ctrl = (busy && !hold) ? word : CTRL_IDLE;

  always_comb begin
    unique case (word.cond)
      COND_NONE:     taken = 1'b0;
      COND_LOOP:     taken = status.more;
      COND_NO_LEN:   taken = status.no_len;
      COND_TOO_LONG: taken = status.too_long;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      unique case (kind)
        KIND_WRITE: begin
          pc_next   = PC_WRITE;
          busy_next = 1'b1;
        end
        KIND_LENGTH: begin
          pc_next   = PC_LENGTH;
          busy_next = 1'b1;
        end
        KIND_EVAL: begin
          pc_next   = PC_EVAL;
          busy_next = 1'b1;
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end else if (busy && !hold) begin
      priority if (taken) begin
        pc_next = word.target;
      end else if (word.done) begin
        busy_next = 1'b0;
      end else begin
        pc_next = pc + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_WRITE;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

@@ sv/lpi_datapath.sv @@
module lpi_datapath #(
  parameter int NUM_STYLES    = 256,
  parameter int PATTERN_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic [7:0]                            style,
  input  logic [5:0]                            position,
  input  logic [7:0]                            letter,
  input  logic [7:0]                            pattern_length,
  input  logic [31:0]                           time_ms,
  input  lpi_pkg::ctrl_t                        ctrl,
  output lpi_pkg::dp_status_t                   status,
  output logic signed [lpi_pkg::BRIGHT_W-1:0]   acc,
  output logic                                  clearing
);
  import lpi_pkg::*;

  localparam int SW      = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
  localparam int PW      = $clog2(PATTERN_DEPTH);
  localparam int ENTRIES = NUM_STYLES * PATTERN_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Wide enough for 100 times any accepted length.
  localparam int RW      = $clog2(STEP_MS * PATTERN_DEPTH);
  localparam int SPW     = RW + RECIP_W;

  // Captured transaction.
  logic [7:0]            style_r;
  logic [5:0]            position_r;
  logic [7:0]            letter_r;
  logic [7:0]            plen_r;
  logic [DIVIDEND_W-1:0] time_r;

  always_ff @(posedge clk) begin
    if (load) begin
      style_r    <= style;
      position_r <= position;
      letter_r   <= letter;
      plen_r     <= pattern_length;
      time_r     <= time_ms;
    end
  end

  logic          style_ok;
  logic          pos_ok;
  logic          too_long;
  logic [SW-1:0] style_idx;
  logic [PW-1:0] pos_idx;

  assign style_ok  = 32'(style_r) < NUM_STYLES;
  assign pos_ok    = 32'(position_r) < PATTERN_DEPTH;
  assign too_long  = 32'(plen_r) >= PATTERN_DEPTH;
  assign style_idx = SW'(style_r);
  assign pos_idx   = PW'(position_r);

  // Length store with a clearing sweep after reset.
  logic [PW-1:0] len_mem [NUM_STYLES];
  logic [PW-1:0] len_q;
  logic [SW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == SW'(NUM_STYLES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      len_mem[clr_idx] <= '0;
    end else if (ctrl.op == OP_WR_LEN && style_ok && !too_long) begin
      len_mem[style_idx] <= PW'(plen_r);
    end
    len_q <= len_mem[style_idx];
  end

  // Shift-subtract divider for the modulo of the time by 100 * length.
  logic [RW-1:0]         rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [RW-1:0]         dvs;
  logic [COUNT_W-1:0]    cnt;
  logic [PW-1:0]         len_r;
  logic [RW+1:0]         trial;
  logic [SPW-1:0]        split_prod;

  assign trial      = {1'b0, rem, quo[DIVIDEND_W-1]} - {2'b00, dvs};
  assign split_prod = SPW'(rem) * SPW'(RECIP_100);

  // The split puts the pattern step in quo; OP_TAKE_FRAC leaves the fraction in rem.
  logic [PW-1:0]     cur;
  logic [PW-1:0]     prev;
  logic [FRAC_W-1:0] frac;

  assign cur  = quo[PW-1:0];
  assign frac = rem[FRAC_W-1:0];
  assign prev = (cur == '0) ? len_r - PW'(1) : cur - PW'(1);

  // Pattern store.
  logic signed [ENTRY_W-1:0] pat_mem [ENTRIES];
  logic signed [ENTRY_W-1:0] rd_data;
  logic [AW-1:0]             base;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic [ENTRY_W-1:0]        letter_val;

  assign base       = AW'(style_idx * PATTERN_DEPTH);
  assign wr_addr    = base + AW'(pos_idx);
  assign rd_addr    = base + AW'((ctrl.op == OP_MAC_CUR) ? prev : cur);
  assign letter_val = {1'b0, letter_r} - LETTER_BASE;

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_WR_LETTER && style_ok && pos_ok) begin
      pat_mem[wr_addr] <= $signed(letter_val);
    end
    rd_data <= pat_mem[rd_addr];
  end

  // Weighting of one pattern entry.
  logic [FRAC_W-1:0]          coef;
  logic signed [FRAC_W:0]     coef_s;
  logic signed [ENTRY_W+FRAC_W:0] prod;
  logic signed [BRIGHT_W-1:0] prod_t;

  assign coef   = (ctrl.op == OP_MAC_PREV) ? FRAC_W'(STEP_MS) - frac : frac;
  assign coef_s = $signed({1'b0, coef});
  assign prod   = rd_data * coef_s;
  assign prod_t = prod[BRIGHT_W-1:0];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD_MOD: begin
        len_r <= len_q;
        dvs   <= RW'(len_q * STEP_MS);
        rem   <= '0;
        quo   <= time_r;
        cnt   <= COUNT_W'(DIVIDEND_W);
      end
      OP_DIV_STEP: begin
        if (!trial[RW+1]) begin
          rem <= trial[RW-1:0];
        end else begin
          rem <= {rem[RW-2:0], quo[DIVIDEND_W-1]};
        end
        quo <= {quo[DIVIDEND_W-2:0], !trial[RW+1]};
        cnt <= cnt - COUNT_W'(1);
      end
      OP_LOAD_SPLIT: begin
        quo <= DIVIDEND_W'(split_prod >> RECIP_SHIFT);
      end
      OP_TAKE_FRAC: begin
        rem <= rem - RW'(cur * STEP_MS);
      end
      OP_MAC_CUR: begin
        acc <= prod_t;
      end
      OP_MAC_PREV: begin
        acc <= acc + prod_t;
      end
      default: begin
      end
    endcase
  end

  assign status.too_long = too_long;
  assign status.no_len   = !style_ok || (len_q == '0);
  assign status.more     = cnt != COUNT_W'(1);

endmodule

@@ sv/light_pattern_interpolator_unit.sv @@
// Channel  Handshake             Payload
// input    in_valid / in_stall   kind, style, position, letter, pattern_length, time_ms
// output   out_valid / out_stall brightness, status
//
// A letter write or an accepted length ends after its store write; a rejected length
// goes on to emit an error result. An evaluation runs the 32-step modulo of the time by
// 100 * length on the shift-subtract divider, then splits the remainder and blends two
// entries; a style with no length, or one out of range, answers with full brightness.
// After reset a clearing pass over all NUM_STYLES entries zeroes the length store; no
// transaction is accepted during it. A result held by out_stall makes the next
// result wait at its final step, and the input stays stalled until that step is done.
module light_pattern_interpolator_unit #(
  parameter int NUM_STYLES    = 256,
  parameter int PATTERN_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [7:0]                          style,
  input  logic [5:0]                          position,
  input  logic [7:0]                          letter,
  input  logic [7:0]                          pattern_length,
  input  logic [31:0]                         time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lpi_pkg::BRIGHT_W-1:0] brightness,
  output logic                                status
);
  import lpi_pkg::*;

  ctrl_t                      ctrl;
  dp_status_t                 dp_status;
  logic                       busy;
  logic                       clearing;
  logic                       start;
  logic                       out_blocked;
  logic signed [BRIGHT_W-1:0] acc;

  assign in_stall    = busy || clearing;
  assign start       = in_valid && !in_stall;
  assign out_blocked = out_valid && out_stall;

  lpi_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .status      (dp_status),
    .out_blocked (out_blocked),
    .ctrl        (ctrl),
    .busy        (busy)
  );

  lpi_datapath #(
    .NUM_STYLES    (NUM_STYLES),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .load           (start),
    .style          (style),
    .position       (position),
    .letter         (letter),
    .pattern_length (pattern_length),
    .time_ms        (time_ms),
    .ctrl           (ctrl),
    .status         (dp_status),
    .acc            (acc),
    .clearing       (clearing)
  );

  // Output register; the sequencer only emits when it is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.emit)
      EMIT_ACC: begin
        brightness <= acc;
        status     <= 1'b0;
      end
      EMIT_FULL: begin
        brightness <= UNIT_FULL;
        status     <= 1'b0;
      end
      EMIT_REJECT: begin
        brightness <= '0;
        status     <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ dv/lpi_level_check.sv @@
`timescale 1ns / 1ps

module lpi_level_check #(
  parameter int NUM_STYLES    = 256,
  parameter int PATTERN_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [7:0]                          style,
  input  logic [5:0]                          position,
  input  logic [7:0]                          letter,
  input  logic [7:0]                          pattern_length,
  input  logic [31:0]                         time_ms,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [lpi_pkg::BRIGHT_W-1:0] brightness,
  input  logic                                status,
  output int                                  mismatches,
  output int                                  pending
);
  import lpi_pkg::*;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  typedef struct packed {
    logic signed [BRIGHT_W-1:0] level;
    logic                       code;
  } outcome_t;

  outcome_t                  outcome_due [$];
  logic signed [ENTRY_W-1:0] letter_level [NUM_STYLES][PATTERN_DEPTH];
  logic [7:0]                style_len [NUM_STYLES];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Level of a style at a given time, blending the current entry with the one before it.
  function automatic logic signed [BRIGHT_W-1:0] blend_level(input logic [7:0] sel,
                                                            input logic [31:0] t);
    int unsigned len, step, cur, prev;
    int          frac;
    if (sel >= NUM_STYLES) return UNIT_FULL;
    len = style_len[sel];
    if (len == 0) return UNIT_FULL;
    if (len == 1) return BRIGHT_W'(int'(letter_level[sel][0]) * STEP_MS);
    step = t / STEP_MS;
    frac = t % STEP_MS;
    cur  = step % len;
    prev = (cur == 0) ? len - 1 : cur - 1;
    return BRIGHT_W'(int'(letter_level[sel][cur]) * frac +
                     int'(letter_level[sel][prev]) * (STEP_MS - frac));
  endfunction

  always @(posedge clk) begin : watch
    outcome_t due;
    if (rst) begin
      for (int i = 0; i < NUM_STYLES; i++) style_len[i] = '0;
      outcome_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, brightness %0d status %0b",
                                    brightness, status));
        end else begin
          due = outcome_due.pop_front();
          if (brightness !== due.level) begin
            report_mismatch($sformatf("brightness %0d, expected %0d", brightness, due.level));
          end
          if (status !== due.code) begin
            report_mismatch($sformatf("status %0b, expected %0b", status, due.code));
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_WRITE: begin
            if (style < NUM_STYLES && position < PATTERN_DEPTH) begin
              letter_level[style][position] = {1'b0, letter} - LETTER_BASE;
            end
          end
          KIND_LENGTH: begin
            // An over-long length leaves the store alone and answers with an error.
            if (pattern_length >= PATTERN_DEPTH) begin
              outcome_due.push_back('{level: '0, code: STATUS_TOO_LONG});
            end else if (style < NUM_STYLES) begin
              style_len[style] = pattern_length;
            end
          end
          KIND_EVAL: begin
            outcome_due.push_back('{level: blend_level(style, time_ms), code: STATUS_OK});
          end
          default: ;
        endcase
      end
    end
    pending = outcome_due.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lpi_pkg::*;

  localparam int         NUM_STYLES    = 256;
  localparam int         PATTERN_DEPTH = 64;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET   = 900;
  localparam int         SETTLE_CYCLES = 120;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 kind;
  logic [7:0]                 style;
  logic [5:0]                 position;
  logic [7:0]                 letter;
  logic [7:0]                 pattern_length;
  logic [31:0]                time_ms;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [BRIGHT_W-1:0] brightness;
  logic                       status;
  int                         mismatches;
  int                         pending;

  // Which pattern entries hold a letter; a length is only set once all entries below it do.
  bit                         letter_known [NUM_STYLES][PATTERN_DEPTH];
  int unsigned                items_sent;

  light_pattern_interpolator_unit #(
    .NUM_STYLES    (NUM_STYLES),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .style          (style),
    .position       (position),
    .letter         (letter),
    .pattern_length (pattern_length),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .brightness     (brightness),
    .status         (status)
  );

  lpi_level_check #(
    .NUM_STYLES    (NUM_STYLES),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_level_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .style          (style),
    .position       (position),
    .letter         (letter),
    .pattern_length (pattern_length),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .brightness     (brightness),
    .status         (status),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side back-pressure: short and long stalls, with free-running stretches between.
  initial begin
    int unsigned hold, r;
    logic        level;
    out_stall = 1'b0;
    hold      = 0;
    level     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          level = 1'b0;
          hold  = $urandom_range(1, 8);
        end else if (r < 60) begin
          level = 1'b0;
          hold  = $urandom_range(50, 200);
        end else if (r < 95) begin
          level = 1'b1;
          hold  = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          hold  = $urandom_range(20, 60);
        end
      end
      out_stall <= level;
      hold--;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((items_sent / 80) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] pick_time(input int unsigned len);
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 999);
      default: return $urandom_range(0, 100 * (len + 1) * 3);
    endcase
  endfunction

  // Entered between a falling and a rising edge; returns when the item meets in_stall low.
  task automatic send_item(input logic [1:0] k, input logic [7:0] sel, input logic [5:0] pos,
                           input logic [7:0] chr, input logic [7:0] len, input logic [31:0] t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(posedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
    end
    @(posedge clk);
    in_valid       <= 1'b1;
    kind           <= k;
    style          <= sel;
    position       <= pos;
    letter         <= chr;
    pattern_length <= len;
    time_ms        <= t;
    do @(negedge clk); while (in_stall);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic write_letter(input logic [7:0] sel, input logic [5:0] pos,
                              input logic [7:0] chr);
    send_item(KIND_WRITE, sel, pos, chr, 8'($urandom), $urandom);
    letter_known[sel][pos] = 1'b1;
  endtask

  task automatic set_length(input logic [7:0] sel, input logic [7:0] len);
    if (len < PATTERN_DEPTH) begin
      for (int i = 0; i < len; i++) begin
        if (!letter_known[sel][i]) write_letter(sel, 6'(i), 8'($urandom));
      end
    end
    send_item(KIND_LENGTH, sel, 6'($urandom), 8'($urandom), len, $urandom);
  endtask

  task automatic evaluate_at(input logic [7:0] sel, input logic [31:0] t);
    send_item(KIND_EVAL, sel, 6'($urandom), 8'($urandom), 8'($urandom), t);
  endtask

  task automatic wait_for_results();
    @(posedge clk) in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    logic [7:0]  sel, len;
    int unsigned evals;
    bit          drained_mid;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_WRITE;
    style          = '0;
    position       = '0;
    letter         = '0;
    pattern_length = '0;
    time_ms        = '0;
    items_sent     = 0;
    drained_mid    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A style with no length reads as full brightness.
    evaluate_at(8'd0, 32'd0);
    send_item(KIND_UNUSED, 8'hFF, 6'h3F, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    set_length(8'd5, 8'd64);
    set_length(8'd5, 8'd255);
    evaluate_at(8'd5, 32'd12345);
    write_letter(8'd1, 6'd0, "m");
    set_length(8'd1, 8'd1);
    evaluate_at(8'd1, 32'hFFFF_FFFF);
    write_letter(8'd2, 6'd63, 8'hFF);
    write_letter(8'd3, 6'd0, 8'h00);
    write_letter(8'd3, 6'd1, 8'hFF);
    write_letter(8'd3, 6'd2, "a");
    write_letter(8'd3, 6'd3, "m");
    set_length(8'd3, 8'd4);
    evaluate_at(8'd3, 32'd0);
    evaluate_at(8'd3, 32'd99);
    evaluate_at(8'd3, 32'd150);
    evaluate_at(8'd3, 32'd399);
    evaluate_at(8'd3, 32'hFFFF_FFFF);
    // Shortening the pattern keeps the letters already stored.
    write_letter(8'd3, 6'd1, "c");
    set_length(8'd3, 8'd2);
    evaluate_at(8'd3, 32'd100);
    evaluate_at(8'd3, 32'd250);
    set_length(8'd3, 8'd0);
    evaluate_at(8'd3, 32'd50);
    set_length(8'd255, 8'd2);
    evaluate_at(8'd255, 32'd199);
    wait_for_results();

    while (items_sent < ITEM_TARGET) begin
      if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
        wait_for_results();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        sel = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        case ($urandom_range(0, 19))
          0, 1:    len = 8'd0;
          2:       len = 8'd63;
          3:       len = 8'($urandom_range(32, 62));
          default: len = 8'($urandom_range(1, 8));
        endcase
        repeat ($urandom_range(0, 2)) write_letter(sel, 6'($urandom), 8'($urandom));
        set_length(sel, len);
        evals = $urandom_range(1, 6);
        repeat (evals) evaluate_at(sel, pick_time(len));
      end else begin
        case ($urandom_range(0, 4))
          0: write_letter(8'($urandom), 6'($urandom), 8'($urandom));
          1: evaluate_at(8'($urandom), $urandom);
          2: set_length(8'($urandom), 8'($urandom_range(64, 255)));
          3: set_length(8'($urandom), 8'($urandom));
          default: send_item(KIND_UNUSED, 8'($urandom), 6'($urandom), 8'($urandom),
                             8'($urandom), $urandom);
        endcase
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lpi_pkg.sv
sv/lpi_sequencer.sv
sv/lpi_datapath.sv
sv/light_pattern_interpolator_unit.sv
dv/lpi_level_check.sv
dv/tb_top.sv
